// ----- hw/rtl/rgb_gray_sobel_edge_magnitude_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the RGB gray Sobel edge magnitude block
// Shared by the modules that carry concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RGB_GRAY_SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define RGB_GRAY_SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RGSEM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RGSEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rgsem_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsem_pkg
// Types, constants and codes shared by the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package rgsem_pkg;

    localparam int MAX_LINE     = 1024;
    localparam int LINE_AW      = $clog2(MAX_LINE);
    localparam int PIX_W        = 8;
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 13;
    localparam int COL_W        = 10;
    localparam int ROW_W        = 12;
    localparam int WSUM_W       = 15;
    localparam int PROD_W       = 31;
    localparam int GRAD_W       = 10;
    localparam int SQ_W         = 2 * GRAD_W;
    localparam int SUM_W        = SQ_W + 1;
    localparam int ROOT_W       = 8;
    localparam int ROOT_SQ_W    = 2 * ROOT_W;
    localparam int APB_DW       = 32;
    localparam int PADDR_W      = 3;
    localparam int REG_IDX_BIT  = 2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_LINE);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(4096);

    // gray = floor((30r + 59g + 11b + 50) / 100)
    localparam int W_RED        = 30;
    localparam int W_GREEN      = 59;
    localparam int W_BLUE       = 11;
    localparam int GRAY_ROUND   = 50;
    // floor(x / 100) == (x * 41944) >> 22 for x below 25600
    localparam int RECIP_100    = 41944;
    localparam int RECIP_SHIFT  = 22;

    localparam int WIN_EDGE     = 2;

    // register index codes (paddr bit REG_IDX_BIT)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             inside_res;
        logic             frame_done;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic load;
        logic shift;
        logic grad;
        logic square;
        logic sum;
        logic root_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic root_last;
        logic out_free;
    } t_status;

endpackage

// ----- hw/rtl/rgsem_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsem_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rgsem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/rgsem_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsem_datapath
// Gray conversion, line stores, 3x3 window, gradients, iterative root, output.
// ----------------------------------------------------------------------------
`include "rgb_gray_sobel_edge_magnitude_defines.svh"

module rgsem_datapath
    import rgsem_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [WIDTH_W-1:0]  i_width,
    input  logic [HEIGHT_W-1:0] i_height,
    input  t_in_item            i_in_item,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item
);

    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_item_col;
    logic               r_inside;
    logic               r_last;
    logic [WSUM_W-1:0]  r_wsum;
    logic [PIX_W-1:0]   r_gray;
    logic [PIX_W-1:0]   r_win [9];
    logic [GRAD_W-1:0]  r_ax;
    logic [GRAD_W-1:0]  r_ay;
    logic [SQ_W-1:0]    r_sqx;
    logic [SQ_W-1:0]    r_sqy;
    logic [SUM_W-1:0]   r_sum;
    logic [ROOT_W-1:0]  r_res;
    logic [ROOT_W-1:0]  r_bit;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic [WIDTH_W-1:0]  width_c;
    logic [HEIGHT_W-1:0] height_c;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;
    logic                col_wrap;
    logic                row_wrap;
    logic [WSUM_W-1:0]   wsum;
    logic [PROD_W-1:0]   gray_prod;
    logic [PIX_W-1:0]    older_rd;
    logic [PIX_W-1:0]    newer_rd;
    logic [GRAD_W-1:0]   gx_pos;
    logic [GRAD_W-1:0]   gx_neg;
    logic [GRAD_W-1:0]   gy_pos;
    logic [GRAD_W-1:0]   gy_neg;
    logic [ROOT_W-1:0]   root_try;
    logic [ROOT_SQ_W-1:0] root_try_sq;
    logic [ROOT_SQ_W-1:0] res_sq;
    logic                root_ovf;

    always_comb begin
        if (i_width < WIDTH_MIN) begin
            width_c = WIDTH_MIN;
        end else if (i_width > WIDTH_MAX) begin
            width_c = WIDTH_MAX;
        end else begin
            width_c = i_width;
        end
        if (i_height < HEIGHT_MIN) begin
            height_c = HEIGHT_MIN;
        end else if (i_height > HEIGHT_MAX) begin
            height_c = HEIGHT_MAX;
        end else begin
            height_c = i_height;
        end
    end

    assign col_inc  = WIDTH_W'(r_col) + WIDTH_W'(1);
    assign row_inc  = HEIGHT_W'(r_row) + HEIGHT_W'(1);
    assign col_wrap = (col_inc >= width_c);
    assign row_wrap = (row_inc >= height_c);

    assign wsum = WSUM_W'(W_RED) * WSUM_W'(i_in_item.red)
                + WSUM_W'(W_GREEN) * WSUM_W'(i_in_item.green)
                + WSUM_W'(W_BLUE) * WSUM_W'(i_in_item.blue)
                + WSUM_W'(GRAY_ROUND);

    assign gray_prod = PROD_W'(r_wsum) * PROD_W'(RECIP_100);

    assign gx_pos = GRAD_W'(r_win[6]) + {1'b0, r_win[7], 1'b0} + GRAD_W'(r_win[8]);
    assign gx_neg = GRAD_W'(r_win[0]) + {1'b0, r_win[1], 1'b0} + GRAD_W'(r_win[2]);
    assign gy_pos = GRAD_W'(r_win[2]) + {1'b0, r_win[5], 1'b0} + GRAD_W'(r_win[8]);
    assign gy_neg = GRAD_W'(r_win[0]) + {1'b0, r_win[3], 1'b0} + GRAD_W'(r_win[6]);

    assign root_try    = r_res | r_bit;
    assign root_try_sq = ROOT_SQ_W'(root_try) * ROOT_SQ_W'(root_try);
    assign res_sq      = ROOT_SQ_W'(r_res) * ROOT_SQ_W'(r_res);
    assign root_ovf    = (r_sum[SUM_W-1:ROOT_SQ_W] != '0);

    rgsem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE)
    ) u_older_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_item_col[LINE_AW-1:0]),
        .i_wdata (newer_rd),
        .i_re    (i_cmd.accept),
        .i_raddr (r_col[LINE_AW-1:0]),
        .o_rdata (older_rd)
    );

    rgsem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE)
    ) u_newer_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_item_col[LINE_AW-1:0]),
        .i_wdata (r_gray),
        .i_re    (i_cmd.accept),
        .i_raddr (r_col[LINE_AW-1:0]),
        .o_rdata (newer_rd)
    );

    // counters, window and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : row_inc[ROW_W-1:0];
                end else begin
                    r_col <= col_inc[COL_W-1:0];
                end
            end
            if (i_cmd.shift) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= older_rd;
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= newer_rd;
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_gray;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-transaction payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item_col <= r_col;
            r_inside   <= (r_row >= ROW_W'(WIN_EDGE)) && (r_col >= COL_W'(WIN_EDGE));
            r_last     <= col_wrap && row_wrap;
            r_wsum     <= wsum;
        end
        if (i_cmd.load) begin
            r_gray <= gray_prod[RECIP_SHIFT +: PIX_W];
        end
        if (i_cmd.grad) begin
            r_ax <= (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
            r_ay <= (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
        end
        if (i_cmd.square) begin
            r_sqx <= SQ_W'(r_ax) * SQ_W'(r_ax);
            r_sqy <= SQ_W'(r_ay) * SQ_W'(r_ay);
        end
        if (i_cmd.sum) begin
            r_sum <= SUM_W'(r_sqx) + SUM_W'(r_sqy);
            r_res <= '0;
            r_bit <= {1'b1, {(ROOT_W-1){1'b0}}};
        end
        if (i_cmd.root_step) begin
            if (SUM_W'(root_try_sq) <= r_sum) begin
                r_res <= root_try;
            end
            r_bit <= r_bit >> 1;
        end
        if (i_cmd.finish) begin
            if (!r_inside) begin
                r_out_item.magnitude <= '0;
            end else if (root_ovf) begin
                r_out_item.magnitude <= '1;
            end else begin
                r_out_item.magnitude <= r_res;
            end
            r_out_item.inside_res <= r_inside;
            r_out_item.frame_done <= r_last;
        end
    end

    assign o_status.root_last = r_bit[0];
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out_item;

    `RGSEM_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, i_cmd.accept && col_wrap && row_wrap, (r_col == '0) && (r_row == '0), "counters did not wrap at frame end")
    `RGSEM_ASSERT_NOW(a_root_bound, i_clk, i_rst_n, i_cmd.finish && !root_ovf, SUM_W'(res_sq) <= r_sum, "root exceeds its operand")
    `RGSEM_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, i_cmd.finish, o_out_valid, "finished result not presented")

endmodule

// ----- hw/rtl/rgsem_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgsem_ctrl
// Sequencer that steps one pixel through the datapath.
// ----------------------------------------------------------------------------
`include "rgb_gray_sobel_edge_magnitude_defines.svh"

module rgsem_ctrl
    import rgsem_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SHIFT,
        S_GRAD,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   n_stall;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        n_stall = r_stall;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_stall    = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.load = 1'b1;
                n_state  = S_SHIFT;
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                n_state   = S_GRAD;
            end
            S_GRAD: begin
                cmd.grad = 1'b1;
                n_state  = S_SQUARE;
            end
            S_SQUARE: begin
                cmd.square = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                cmd.sum = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (i_status.root_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    cmd.finish = 1'b1;
                    n_stall    = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_in_stall = r_stall;
    assign o_cmd      = cmd;

    `RGSEM_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, o_cmd.accept, r_state == S_LOAD, "accepted transaction did not start")
    `RGSEM_ASSERT_NOW(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall, "input open while busy")
    `RGSEM_ASSERT_NEXT(a_root_ends, i_clk, i_rst_n, (r_state == S_ROOT) && i_status.root_last, r_state == S_FINISH, "root iteration overran")

endmodule

// ----- hw/rtl/rgb_gray_sobel_edge_magnitude.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gray_sobel_edge_magnitude
// Sobel 3x3 edge magnitude on an RGB raster stream.
// ----------------------------------------------------------------------------
// Each accepted RGB pixel is turned to gray, pushed through two 1024-entry line
// stores and a 3x3 window, and yields one result for the pixel one row up and one
// column left: the Sobel magnitude (saturated at 255, zero outside the image), an
// inside flag and a frame-done flag. One pixel is processed at a time: its result
// register loads in the finish step, after the load, shift, gradient, square, sum
// and 8-step bit-serial square root steps, and the next pixel can be taken in the
// cycle after it. A stalled earlier result holds the final step; the next pixel
// is taken while that result waits. image_width sits at 0x0, image_height at
// 0x4; the user must write both only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_edge_magnitude
    import rgsem_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic                cfg_wr;
    t_cmd                cmd;
    t_status             status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[REG_IDX_BIT])
                REG_WIDTH:  r_width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: r_height <= pwdata[HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_IDX_BIT])
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    rgsem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rgsem_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- bench/rgb_gray_sobel_edge_magnitude_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gray_sobel_edge_magnitude_checker
// Passive checker for the Sobel edge magnitude block. It follows register
// writes on the APB port and keeps its own line stores, window and counters.
// It predicts one result per accepted pixel and compares every accepted result
// field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_edge_magnitude_checker
    import rgsem_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_item           i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_item          i_out_item,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [APB_DW-1:0]  i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int GRAY_DIV   = 100;
    localparam int ROOT_LIMIT = 65536;
    localparam int REPORT_CAP = 100;

    logic [PIX_W-1:0]    older_row [MAX_LINE];
    logic [PIX_W-1:0]    newer_row [MAX_LINE];
    logic [PIX_W-1:0]    win [9];
    int                  col_cnt;
    int                  row_cnt;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    t_out_item           expected_edges [$];
    t_out_item           want;
    int                  fail_total = 0;
    int                  result_idx = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_total < REPORT_CAP) $display("%0t ERROR %s", $time, msg);
        fail_total++;
    endtask

    function automatic t_out_item sobel_predict(input t_in_item px);
        int        w;
        int        h;
        int        gray;
        int        slot;
        int        gx;
        int        gy;
        int        sq;
        int        root;
        int        t;
        t_out_item res;
        w = (width_reg < WIDTH_MIN) ? int'(WIDTH_MIN) :
            (width_reg > WIDTH_MAX) ? int'(WIDTH_MAX) : int'(width_reg);
        h = (height_reg < HEIGHT_MIN) ? int'(HEIGHT_MIN) :
            (height_reg > HEIGHT_MAX) ? int'(HEIGHT_MAX) : int'(height_reg);
        gray = (W_RED * int'(px.red) + W_GREEN * int'(px.green) + W_BLUE * int'(px.blue)
                + GRAY_ROUND) / GRAY_DIV;
        slot = col_cnt % MAX_LINE;
        res.inside_res = (row_cnt >= WIN_EDGE) && (col_cnt >= WIN_EDGE);
        res.frame_done = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
        res.magnitude  = '0;

        for (int k = 0; k < 3; k++) begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = older_row[slot];
        win[5] = newer_row[slot];
        win[8] = PIX_W'(gray);
        older_row[slot] = newer_row[slot];
        newer_row[slot] = PIX_W'(gray);

        if (res.inside_res) begin
            gx = int'(win[6]) + 2 * int'(win[7]) + int'(win[8])
               - int'(win[0]) - 2 * int'(win[1]) - int'(win[2]);
            gy = int'(win[2]) + 2 * int'(win[5]) + int'(win[8])
               - int'(win[0]) - 2 * int'(win[3]) - int'(win[6]);
            sq = gx * gx + gy * gy;
            if (sq >= ROOT_LIMIT) begin
                root = 255;
            end else begin
                root = 0;
                for (int b = 7; b >= 0; b--) begin
                    t = root | (1 << b);
                    if (t * t <= sq) root = t;
                end
            end
            res.magnitude = PIX_W'(root);
        end

        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LINE; i++) begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            for (int i = 0; i < 9; i++) win[i] = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            expected_edges.delete();
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[REG_IDX_BIT] == REG_HEIGHT) height_reg = i_pwdata[HEIGHT_W-1:0];
                else width_reg = i_pwdata[WIDTH_W-1:0];
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_edges.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected: %p",
                                              result_idx, i_out_item));
                end else begin
                    want = expected_edges.pop_front();
                    if (i_out_item.magnitude !== want.magnitude)
                        report_mismatch($sformatf("result %0d magnitude %0d, expected %0d",
                                        result_idx, i_out_item.magnitude, want.magnitude));
                    if (i_out_item.inside_res !== want.inside_res)
                        report_mismatch($sformatf("result %0d inside_res %0b, expected %0b",
                                        result_idx, i_out_item.inside_res, want.inside_res));
                    if (i_out_item.frame_done !== want.frame_done)
                        report_mismatch($sformatf("result %0d frame_done %0b, expected %0b",
                                        result_idx, i_out_item.frame_done, want.frame_done));
                end
                result_idx++;
            end

            if (i_in_valid && !i_in_stall) expected_edges.push_back(sobel_predict(i_in_item));

            o_pending <= expected_edges.size();
        end
        o_fail_count <= fail_total;
    end

endmodule

// ----- bench/tb_rgb_gray_sobel_edge_magnitude.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_gray_sobel_edge_magnitude
// Stimulus and verdict for the Sobel edge magnitude block. Directed frames
// cover black/white saturation, single color channels, register clamping and
// a mid-frame width change; then a short run at an over-range width, many
// small random frames with mixed content, and a tallest frame cut short by a
// height change.
// Both channels idle at random; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_rgb_gray_sobel_edge_magnitude;
    import rgsem_pkg::*;

    typedef enum int {
        CONTENT_NOISE,
        CONTENT_FLAT,
        CONTENT_BINARY
    } content_e;

    localparam int        RANDOM_ITEMS = 700;
    localparam int        WIDE_ITEMS   = 64;
    localparam int        DRAIN_LIMIT  = 20000;
    localparam int        TAIL_CYCLES  = 40;
    localparam logic [8:0] SAT_MASK    = 9'b110100000;
    localparam t_in_item  BLACK        = '{8'h00, 8'h00, 8'h00};
    localparam t_in_item  WHITE        = '{8'hFF, 8'hFF, 8'hFF};

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_item           in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_item;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [APB_DW-1:0]  pwdata    = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;

    content_e           row_content = CONTENT_NOISE;
    t_in_item           flat_base   = '0;
    logic               quiet_in    = 1'b0;
    int                 stall_run   = 0;
    logic               stall_now   = 1'b0;
    int                 stall_pick;
    int                 random_sent;
    int                 drain;
    int                 w_val;
    int                 h_val;
    int                 frame_px;

    t_in_item tone_px [0:11] = '{
        '{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF},
        '{8'h01, 8'h01, 8'h01}, '{8'hFE, 8'hFE, 8'hFE}, '{8'h80, 8'h40, 8'h20},
        '{8'hFF, 8'hFF, 8'h00}, '{8'h00, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'hFF},
        '{8'h11, 8'hC8, 8'h5A}, '{8'h03, 8'hFA, 8'h07}, '{8'h64, 8'h64, 8'h64}
    };

    rgb_gray_sobel_edge_magnitude dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    rgb_gray_sobel_edge_magnitude_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL rgb_gray_sobel_edge_magnitude");
        $finish;
    end

    // receiver back-pressure: short bursts, occasional long stalls, quiet stretches
    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 10) begin
                stall_now = 1'b0;
                stall_run = $urandom_range(50, 200);
            end else if (stall_pick < 55) begin
                stall_now = 1'b0;
                stall_run = $urandom_range(1, 6);
            end else if (stall_pick < 95) begin
                stall_now = 1'b1;
                stall_run = $urandom_range(1, 4);
            end else begin
                stall_now = 1'b1;
                stall_run = $urandom_range(10, 40);
            end
        end
        stall_run = stall_run - 1;
        out_stall <= stall_now;
    end

    function automatic logic [PADDR_W-1:0] reg_addr(input logic idx);
        return PADDR_W'(idx) << REG_IDX_BIT;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_in) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in_item make_pixel();
        t_in_item px;
        case (row_content)
            CONTENT_NOISE: begin
                px = t_in_item'(24'($urandom()));
            end
            CONTENT_FLAT: begin
                px.red   = flat_base.red ^ 8'($urandom_range(0, 7));
                px.green = flat_base.green ^ 8'($urandom_range(0, 7));
                px.blue  = flat_base.blue ^ 8'($urandom_range(0, 7));
            end
            default: begin
                px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
        endcase
        return px;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int w, input int h);
        logic [APB_DW-1:0] data;
        wait_drained();
        data = $urandom();
        data[WIDTH_W-1:0] = WIDTH_W'(w);
        apb_write(reg_addr(REG_WIDTH), data);
        data = $urandom();
        data[HEIGHT_W-1:0] = HEIGHT_W'(h);
        apb_write(reg_addr(REG_HEIGHT), data);
    endtask

    task automatic send_pixel(input t_in_item px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= px;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_run(input int count, input int row_len, input int pause_at);
        quiet_in = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
            if (i % row_len == 0) begin
                row_content = content_e'($urandom_range(0, 2));
                flat_base   = t_in_item'(24'($urandom()));
            end
            if (i == pause_at) wait_drained();
            send_pixel(make_pixel());
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // 3x3 through clamped register values, corner pattern that saturates
        configure(0, 2);
        for (int i = 0; i < 9; i++) send_pixel(SAT_MASK[i] ? WHITE : BLACK);

        // single channels and rounding values; width cut from 5 to 3 mid-frame
        configure(5, 3);
        for (int i = 0; i < 8; i++) send_pixel(tone_px[i]);
        wait_drained();
        apb_write(reg_addr(REG_WIDTH), APB_DW'(3));
        for (int i = 8; i < 12; i++) send_pixel(tone_px[i]);

        // register above range clamps to MAX_LINE
        configure(2047, 3);
        send_run(WIDE_ITEMS, WIDE_ITEMS, -1);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            w_val = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h_val = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            configure(w_val, h_val);
            if (w_val < 3) w_val = 3;
            if (h_val < 3) h_val = 3;
            frame_px = w_val * h_val * $urandom_range(1, 3);
            send_run(frame_px, w_val,
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, frame_px - 1) : -1);
            random_sent += frame_px;
        end

        // tallest frame, then height cut to 3 while the row counter is far beyond it
        configure(3, 8191);
        send_run(90, 3, -1);
        wait_drained();
        apb_write(reg_addr(REG_HEIGHT), APB_DW'(3));
        send_run(3, 3, -1);

        in_valid <= 1'b0;
        drain = 0;
        do begin
            @(posedge clk);
            drain++;
        end while (pending != 0 && drain < DRAIN_LIMIT);
        if (pending != 0) $display("%0t ERROR %0d results never arrived", $time, pending);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS rgb_gray_sobel_edge_magnitude");
        end else begin
            $display("FAIL rgb_gray_sobel_edge_magnitude");
        end
        $finish;
    end

endmodule

// ----- rgb_gray_sobel_edge_magnitude.f -----
+incdir+hw/rtl
hw/rtl/rgsem_pkg.sv
hw/rtl/rgsem_ram.sv
hw/rtl/rgsem_datapath.sv
hw/rtl/rgsem_ctrl.sv
hw/rtl/rgb_gray_sobel_edge_magnitude.sv
bench/rgb_gray_sobel_edge_magnitude_checker.sv
bench/tb_rgb_gray_sobel_edge_magnitude.sv
